// ===== hw/rtl/tph_pkg.sv =====
// Shared types, constants and the key compare of the task priority heap.
package tph_pkg;

  // Heap size and the widths that follow from it.
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = $clog2(CAPACITY + 2);
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Fixed field widths of the item interface.
  localparam int unsigned ID_W   = 8;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned SC_W   = 16;
  localparam int unsigned OCC_W  = 7;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2
  } tph_op_e;

  // Status codes of a result item.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } tph_status_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] priority_req;
    logic [SC_W-1:0]   sched_count;
  } tph_in_t;

  typedef struct packed {
    logic [ID_W-1:0]  popped_id;
    logic [1:0]       status;
    logic [OCC_W-1:0] occupancy;
  } tph_out_t;

  // One heap entry as it sits in the store.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [SC_W-1:0]   count;
  } tph_entry_t;

  // True when entry a must sit above entry b: higher priority, then lower count.
  function automatic logic key_better(tph_entry_t a, tph_entry_t b);
    return (a.prio > b.prio) || ((a.prio == b.prio) && (a.count < b.count));
  endfunction

endpackage

// ===== hw/rtl/task_priority_heap.sv =====
// Task ready queue kept as a binary max heap in a single-port entry memory.
// Insert sifts upward; pop moves the last entry to the root and sifts downward; remove scans
// for the id, moves the last entry into its place and sifts downward, then upward.
// Only one item is in flight; the next item is taken in the cycle after the result loads.
// Reset clears the entry count, the sequencer and the output valid; the entry memory is
// not cleared, since only entries below the count are ever read.
module task_priority_heap
  import tph_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tph_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tph_out_t out_data_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_ROOT,
    S_POP_LAST,
    S_RM_RD,
    S_RM_CHK,
    S_RM_LAST,
    S_DN_CHK,
    S_DN_RDR,
    S_DN_CMP,
    S_DN_WR2,
    S_UP_LOAD,
    S_UP_LD2,
    S_UP_CHK,
    S_UP_CMP,
    S_UP_WR2,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  rm_pos_q, rm_pos_d;
  logic [POS_W-1:0]  nxt_q, nxt_d;
  tph_entry_t        cur_q, cur_d;
  tph_entry_t        lv_q, lv_d;
  tph_entry_t        tmp_q, tmp_d;
  logic              have_r_q, have_r_d;
  logic              then_up_q, then_up_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [ID_W-1:0]   popped_q, popped_d;
  tph_status_e       status_q, status_d;
  logic              out_valid_q, out_valid_d;
  tph_out_t          out_data_q, out_data_d;

  // Entry memory with one write and one registered read per cycle.
  tph_entry_t        mem_q [CAPACITY];
  tph_entry_t        rd_q;
  logic              we, re;
  logic [ADDR_W-1:0] wa, ra;
  tph_entry_t        wd;

  // Heap positions start at one; memory addresses at zero.
  function automatic logic [ADDR_W-1:0] addr_of(logic [POS_W-1:0] p);
    logic [POS_W-1:0] t;
    t = p - POS_W'(1);
    return t[ADDR_W-1:0];
  endfunction

  logic [POS_W:0]   lc, rc, cnt_ext;
  logic [POS_W-1:0] parent, cnt_inc;
  logic             pick_left;
  logic [POS_W-1:0] child;
  tph_entry_t       child_v;
  tph_entry_t       new_entry;

  assign lc        = {pos_q, 1'b0};
  assign rc        = {pos_q, 1'b1};
  assign cnt_ext   = (POS_W + 1)'(count_q);
  assign parent    = pos_q >> 1;
  assign cnt_inc   = POS_W'(count_q) + POS_W'(1);
  assign new_entry = '{id: in_data_i.task_id, prio: in_data_i.priority_req,
                       count: in_data_i.sched_count};

  // The right child wins unless the left is strictly better or the right is absent.
  assign pick_left = !have_r_q || key_better(lv_q, rd_q);
  assign child     = pick_left ? lc[POS_W-1:0] : rc[POS_W-1:0];
  assign child_v   = pick_left ? lv_q : rd_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Sequencer: next state, datapath registers and memory controls.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    rm_pos_d    = rm_pos_q;
    nxt_d       = nxt_q;
    cur_d       = cur_q;
    lv_d        = lv_q;
    tmp_d       = tmp_q;
    have_r_d    = have_r_q;
    then_up_d   = then_up_q;
    id_d        = id_q;
    popped_d    = popped_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    we          = 1'b0;
    wa          = '0;
    wd          = cur_q;
    re          = 1'b0;
    ra          = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          id_d     = in_data_i.task_id;
          popped_d = '0;
          status_d = STAT_OK;
          state_d  = S_DONE;
          case (in_data_i.operation)
            OP_INSERT: begin
              if (count_q >= CNT_W'(CAPACITY)) begin
                status_d = STAT_FULL;
              end else begin
                we      = 1'b1;
                wa      = addr_of(cnt_inc);
                wd      = new_entry;
                cur_d   = new_entry;
                count_d = count_q + CNT_W'(1);
                pos_d   = cnt_inc;
                state_d = S_UP_CHK;
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                re      = 1'b1;
                ra      = addr_of(POS_W'(1));
                state_d = S_POP_ROOT;
              end
            end
            OP_REMOVE: begin
              status_d = STAT_NOT_FOUND;
              pos_d    = POS_W'(1);
              state_d  = S_RM_RD;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // Pop: take the root id, then move the last entry to the root.
      S_POP_ROOT: begin
        popped_d = rd_q.id;
        re       = 1'b1;
        ra       = addr_of(POS_W'(count_q));
        state_d  = S_POP_LAST;
      end
      S_POP_LAST: begin
        we        = 1'b1;
        wa        = addr_of(POS_W'(1));
        wd        = rd_q;
        cur_d     = rd_q;
        count_d   = count_q - CNT_W'(1);
        pos_d     = POS_W'(1);
        then_up_d = 1'b0;
        state_d   = S_DN_CHK;
      end

      // Remove: scan from the lowest position for the first matching id.
      S_RM_RD: begin
        if (pos_q > POS_W'(count_q)) begin
          state_d = S_DONE;
        end else begin
          re      = 1'b1;
          ra      = addr_of(pos_q);
          state_d = S_RM_CHK;
        end
      end
      S_RM_CHK: begin
        if (rd_q.id == id_q) begin
          re      = 1'b1;
          ra      = addr_of(POS_W'(count_q));
          state_d = S_RM_LAST;
        end else begin
          pos_d   = pos_q + POS_W'(1);
          state_d = S_RM_RD;
        end
      end
      S_RM_LAST: begin
        we        = 1'b1;
        wa        = addr_of(pos_q);
        wd        = rd_q;
        cur_d     = rd_q;
        count_d   = count_q - CNT_W'(1);
        rm_pos_d  = pos_q;
        then_up_d = 1'b1;
        status_d  = STAT_OK;
        state_d   = S_DN_CHK;
      end

      // Downward sift: read both children, pick one, swap when strictly better.
      S_DN_CHK: begin
        if (lc > cnt_ext) begin
          state_d = then_up_q ? S_UP_LOAD : S_DONE;
        end else begin
          re       = 1'b1;
          ra       = addr_of(lc[POS_W-1:0]);
          have_r_d = (rc <= cnt_ext);
          state_d  = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        lv_d = rd_q;
        if (have_r_q) begin
          re = 1'b1;
          ra = addr_of(rc[POS_W-1:0]);
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (key_better(child_v, cur_q)) begin
          we      = 1'b1;
          wa      = addr_of(child);
          wd      = cur_q;
          tmp_d   = child_v;
          nxt_d   = child;
          state_d = S_DN_WR2;
        end else begin
          cur_d   = child_v;
          pos_d   = child;
          state_d = S_DN_CHK;
        end
      end
      S_DN_WR2: begin
        we      = 1'b1;
        wa      = addr_of(pos_q);
        wd      = tmp_q;
        pos_d   = nxt_q;
        state_d = S_DN_CHK;
      end

      // Upward sift after a remove starts from the entry now at the removed position.
      S_UP_LOAD: begin
        if (rm_pos_q > POS_W'(count_q)) begin
          state_d = S_DONE;
        end else begin
          re      = 1'b1;
          ra      = addr_of(rm_pos_q);
          pos_d   = rm_pos_q;
          state_d = S_UP_LD2;
        end
      end
      S_UP_LD2: begin
        cur_d   = rd_q;
        state_d = S_UP_CHK;
      end

      // Upward sift: compare with the parent up to the root.
      S_UP_CHK: begin
        if (pos_q > POS_W'(1)) begin
          re      = 1'b1;
          ra      = addr_of(parent);
          state_d = S_UP_CMP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_UP_CMP: begin
        if (key_better(cur_q, rd_q)) begin
          we      = 1'b1;
          wa      = addr_of(parent);
          wd      = cur_q;
          tmp_d   = rd_q;
          state_d = S_UP_WR2;
        end else begin
          cur_d   = rd_q;
          pos_d   = parent;
          state_d = S_UP_CHK;
        end
      end
      S_UP_WR2: begin
        we      = 1'b1;
        wa      = addr_of(pos_q);
        wd      = tmp_q;
        pos_d   = parent;
        state_d = S_UP_CHK;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_data_d.popped_id = popped_q;
          out_data_d.status    = status_q;
          out_data_d.occupancy = OCC_W'(count_q);
          state_d              = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      rm_pos_q    <= '0;
      nxt_q       <= '0;
      cur_q       <= '0;
      lv_q        <= '0;
      tmp_q       <= '0;
      have_r_q    <= 1'b0;
      then_up_q   <= 1'b0;
      id_q        <= '0;
      popped_q    <= '0;
      status_q    <= STAT_OK;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      rm_pos_q    <= rm_pos_d;
      nxt_q       <= nxt_d;
      cur_q       <= cur_d;
      lv_q        <= lv_d;
      tmp_q       <= tmp_d;
      have_r_q    <= have_r_d;
      then_up_q   <= then_up_d;
      id_q        <= id_d;
      popped_q    <= popped_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  // Entry memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem_q[ra];
    end
  end

endmodule

// ===== hw/rtl/tph_checker.sv =====
// Port-level checker for the task priority heap, bound to the top level.
module tph_port_checker
  import tph_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input tph_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input tph_out_t out_data_o
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Count items accepted whose result has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  // The block is busy in the cycle after it takes an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> in_stall_o)
    else $error("heap took two items back to back");

  // A result only ever shows for an item that was accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o |-> (pend_q != 2'd0) && (pend_q <= 2'd2))
    else $error("result without a pending item");

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Empty and full statuses agree with the reported occupancy; an empty pop reports no id.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && (out_data_o.status == STAT_EMPTY)
                   |-> (out_data_o.occupancy == '0) && (out_data_o.popped_id == '0))
    else $error("empty pop with entries or an id");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && (out_data_o.status == STAT_FULL)
                   |-> (out_data_o.occupancy == OCC_W'(CAPACITY)))
    else $error("full insert below capacity");

endmodule

bind task_priority_heap tph_port_checker u_tph_checker (.*);
